FILE: hdl/mph_pkg.sv
package mph_pkg;

  localparam int MAX_PACKET_DEF = 256;

  localparam int CFG_AW = 3;
  localparam logic REG_MAX_PATH = 1'b0;
  localparam logic [7:0] MAX_PATH_RESET = 8'd64;

  localparam logic [1:0] RT_TRANSPORT_A = 2'd0;
  localparam logic [1:0] RT_TRANSPORT_B = 2'd3;
  localparam logic [1:0] TIDX_LAST = 2'd3;

  typedef enum logic [2:0] {
    ROLE_HEADER,
    ROLE_TRANSPORT,
    ROLE_PATH_LEN,
    ROLE_PATH,
    ROLE_PAYLOAD,
    ROLE_DISCARD
  } role_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TOO_SHORT,
    ST_TRANSPORT_CUT,
    ST_NO_PATH_LEN,
    ST_PATH_TOO_LONG,
    ST_PATH_CUT
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } beat_t;

endpackage

FILE: hdl/mph_if.sv
interface mph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source(output valid, data_byte, last, input ready);
  modport sink(input valid, data_byte, last, output ready);
endinterface

interface mph_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  role;
  logic [7:0]  data_out;
  logic [1:0]  route_type;
  logic [3:0]  payload_type;
  logic [1:0]  version;
  logic [15:0] code_one;
  logic [15:0] code_two;
  logic [2:0]  hash_bytes;
  logic [5:0]  hops;
  logic [7:0]  payload_length;
  logic [2:0]  status;
  logic        done_res;

  modport source(output valid, role, data_out, route_type, payload_type, version,
                 code_one, code_two, hash_bytes, hops, payload_length, status,
                 done_res, input ready);
  modport sink(input valid, role, data_out, route_type, payload_type, version,
               code_one, code_two, hash_bytes, hops, payload_length, status,
               done_res, output ready);
endinterface

FILE: hdl/mph_cfg.sv
module mph_cfg
  import mph_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [7:0]        max_path_bytes
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_path_bytes <= MAX_PATH_RESET;
    end else if (wr_en && (paddr[CFG_AW-1:2] == REG_MAX_PATH)) begin
      max_path_bytes <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_AW-1:2] == REG_MAX_PATH) begin
      prdata = {24'd0, max_path_bytes};
    end
  end

endmodule

FILE: hdl/mph_in_stage.sv
module mph_in_stage
  import mph_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  mph_in_if.sink pkt,
  output logic  s1_valid,
  output beat_t s1_beat,
  input  logic  s1_take
);

  assign pkt.ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.ready) begin
      s1_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.ready) begin
      s1_beat.data_byte <= pkt.data_byte;
      s1_beat.last      <= pkt.last;
    end
  end

endmodule

FILE: hdl/mph_core.sv
module mph_core
  import mph_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s1_valid,
  input  beat_t      s1_beat,
  output logic       s1_take,
  input  logic [7:0] max_path_bytes,
  mph_out_if.source  res
);

  localparam int CapInt = (MAX_PACKET < 255) ? MAX_PACKET : 255;
  localparam logic [7:0] PayloadCap = 8'(CapInt);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TRANSPORT,
    PH_PATH_LEN,
    PH_PATH,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  tidx, tidx_next;
  logic [7:0]  header_byte, header_byte_next;
  logic [15:0] first_code, first_code_next;
  logic [15:0] second_code, second_code_next;
  logic [7:0]  path_length_byte, path_length_byte_next;
  logic [7:0]  path_left, path_left_next;
  logic [7:0]  payload_count, payload_count_next;

  role_t       role_c;
  status_t     status_c;
  logic [7:0]  b;
  logic        last;
  logic [2:0]  hs_in;
  logic [7:0]  pb;
  logic        advance;

  assign b       = s1_beat.data_byte;
  assign last    = s1_beat.last;
  assign s1_take = !res.valid || res.ready;
  assign advance = s1_valid && s1_take;
  assign hs_in   = {1'b0, b[7:6]} + 3'd1;
  assign pb      = {5'd0, hs_in} * {2'd0, b[5:0]};

  always_comb begin
    phase_next            = phase;
    tidx_next             = tidx;
    header_byte_next      = header_byte;
    first_code_next       = first_code;
    second_code_next      = second_code;
    path_length_byte_next = path_length_byte;
    path_left_next        = path_left;
    payload_count_next    = payload_count;
    status_c              = ST_OK;
    role_c                = ROLE_HEADER;
    case (phase)
      PH_HEADER: begin
        role_c                = ROLE_HEADER;
        header_byte_next      = b;
        tidx_next             = 2'd0;
        first_code_next       = '0;
        second_code_next      = '0;
        path_length_byte_next = '0;
        path_left_next        = '0;
        payload_count_next    = '0;
        if (last) begin
          status_c = ST_TOO_SHORT;
        end
        if (b[1:0] == RT_TRANSPORT_A || b[1:0] == RT_TRANSPORT_B) begin
          phase_next = PH_TRANSPORT;
        end else begin
          phase_next = PH_PATH_LEN;
        end
      end
      PH_TRANSPORT: begin
        role_c    = ROLE_TRANSPORT;
        tidx_next = tidx + 2'd1;
        case (tidx)
          2'd0:    first_code_next[7:0]   = b;
          2'd1:    first_code_next[15:8]  = b;
          2'd2:    second_code_next[7:0]  = b;
          default: second_code_next[15:8] = b;
        endcase
        if (last) begin
          status_c = (tidx == TIDX_LAST) ? ST_NO_PATH_LEN : ST_TRANSPORT_CUT;
        end
        if (tidx == TIDX_LAST) begin
          phase_next = PH_PATH_LEN;
        end
      end
      PH_PATH_LEN: begin
        role_c                = ROLE_PATH_LEN;
        path_length_byte_next = b;
        if (pb > max_path_bytes) begin
          phase_next = PH_DISCARD;
          if (last) begin
            status_c = ST_PATH_TOO_LONG;
          end
        end else begin
          path_left_next = pb;
          phase_next     = (pb != 8'd0) ? PH_PATH : PH_PAYLOAD;
          if (last && pb != 8'd0) begin
            status_c = ST_PATH_CUT;
          end
        end
      end
      PH_PATH: begin
        role_c = ROLE_PATH;
        if (path_left != 8'd0) begin
          path_left_next = path_left - 8'd1;
        end
        if (path_left_next == 8'd0) begin
          phase_next = PH_PAYLOAD;
        end else if (last) begin
          status_c = ST_PATH_CUT;
        end
      end
      PH_PAYLOAD: begin
        role_c = ROLE_PAYLOAD;
        if (payload_count < PayloadCap) begin
          payload_count_next = payload_count + 8'd1;
        end
      end
      PH_DISCARD: begin
        role_c = ROLE_DISCARD;
        if (last) begin
          status_c = ST_PATH_TOO_LONG;
        end
      end
      default: begin
        role_c     = ROLE_HEADER;
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      tidx             <= '0;
      header_byte      <= '0;
      first_code       <= '0;
      second_code      <= '0;
      path_length_byte <= '0;
      path_left        <= '0;
      payload_count    <= '0;
      res.valid        <= 1'b0;
    end else begin
      if (s1_take) begin
        res.valid <= s1_valid;
      end
      if (advance) begin
        res.role           <= role_c;
        res.data_out       <= b;
        res.route_type     <= header_byte_next[1:0];
        res.payload_type   <= header_byte_next[5:2];
        res.version        <= header_byte_next[7:6];
        res.code_one       <= first_code_next;
        res.code_two       <= second_code_next;
        res.hash_bytes     <= {1'b0, path_length_byte_next[7:6]} + 3'd1;
        res.hops           <= path_length_byte_next[5:0];
        res.payload_length <= (last && status_c == ST_OK) ? payload_count_next : 8'd0;
        res.status         <= status_c;
        res.done_res       <= last;
        if (last) begin
          phase            <= PH_HEADER;
          tidx             <= '0;
          header_byte      <= '0;
          first_code       <= '0;
          second_code      <= '0;
          path_length_byte <= '0;
          path_left        <= '0;
          payload_count    <= '0;
        end else begin
          phase            <= phase_next;
          tidx             <= tidx_next;
          header_byte      <= header_byte_next;
          first_code       <= first_code_next;
          second_code      <= second_code_next;
          path_length_byte <= path_length_byte_next;
          path_left        <= path_left_next;
          payload_count    <= payload_count_next;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> phase == PH_HEADER)
    else $error("packet end did not return to header phase");

  a_path_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PATH |-> path_left != 8'd0)
    else $error("path phase with no path bytes left");

  a_tidx_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_TRANSPORT |-> tidx == 2'd0)
    else $error("transport index not cleared outside transport phase");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    payload_count <= PayloadCap)
    else $error("payload count above cap");

  a_summary_on_done: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.done_res |-> res.status == ST_OK && res.payload_length == 8'd0)
    else $error("status or length set on a non-final beat");
`endif

endmodule

FILE: hdl/mesh_packet_header_parser.sv
// Path of an accepted input beat to its result beat: the input register, then the
// parse logic into the result register.
// Throughput: one byte per cycle, set by the single pass of parse logic between the
// two registers; both registers advance together while the result side takes beats.
// Reset (rst, synchronous): empties both registers, returns the parser to expect a
// header byte with all packet fields cleared, and sets max_path_bytes to 64.
module mesh_packet_header_parser
  import mph_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mph_in_if.sink            pkt,
  mph_out_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic       s1_valid;
  beat_t      s1_beat;
  logic       s1_take;
  logic [7:0] max_path_bytes;

  mph_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .max_path_bytes (max_path_bytes)
  );

  mph_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_take  (s1_take)
  );

  mph_core #(
    .MAX_PACKET (MAX_PACKET)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .s1_valid       (s1_valid),
    .s1_beat        (s1_beat),
    .s1_take        (s1_take),
    .max_path_bytes (max_path_bytes),
    .res            (res)
  );

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import mph_pkg::*;

  typedef struct packed {
    role_t       role;
    logic [7:0]  data_out;
    logic [1:0]  route_type;
    logic [3:0]  payload_type;
    logic [1:0]  version;
    logic [15:0] code_one;
    logic [15:0] code_two;
    logic [2:0]  hash_bytes;
    logic [5:0]  hops;
    logic [7:0]  payload_length;
    status_t     status;
    logic        done_res;
  } parse_result_t;

  class header_scoreboard;
    parse_result_t want_q[$];
    int unsigned   faults;
    int unsigned   payload_cap;
    logic [7:0]    max_path;
    role_t         phase;
    logic [8:0]    byte_count;
    logic [7:0]    header_byte;
    logic [15:0]   code_a;
    logic [15:0]   code_b;
    logic [7:0]    path_len_byte;
    logic [7:0]    path_left;
    logic [7:0]    payload_count;

    function new(int unsigned max_packet);
      payload_cap = (max_packet < 255) ? max_packet : 255;
      max_path    = MAX_PATH_RESET;
      faults      = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      phase         = ROLE_HEADER;
      byte_count    = '0;
      header_byte   = '0;
      code_a        = '0;
      code_b        = '0;
      path_len_byte = '0;
      path_left     = '0;
      payload_count = '0;
    endfunction

    function void set_max_path(logic [7:0] v);
      max_path = v;
    endfunction

    // accepted input beat -> expected result beat
    function void note_beat(logic [7:0] b, logic is_last);
      parse_result_t r;
      role_t         nxt;
      status_t       st;
      logic [1:0]    k;
      int unsigned   pb;
      r       = '0;
      r.role  = phase;
      st      = ST_OK;
      nxt     = phase;
      if (phase != ROLE_HEADER && byte_count < 9'd511) byte_count++;
      case (phase)
        ROLE_HEADER: begin
          clear_packet();
          header_byte = b;
          byte_count  = 9'd1;
          if (is_last) st = ST_TOO_SHORT;
          else if (b[1:0] == RT_TRANSPORT_A || b[1:0] == RT_TRANSPORT_B) nxt = ROLE_TRANSPORT;
          else nxt = ROLE_PATH_LEN;
        end
        ROLE_TRANSPORT: begin
          k = 2'(byte_count - 9'd2);
          // little-endian codes: k[1] picks the code, k[0] the byte
          if (k[1]) begin
            if (k[0]) code_b[15:8] = b;
            else code_b[7:0] = b;
          end else begin
            if (k[0]) code_a[15:8] = b;
            else code_a[7:0] = b;
          end
          if (is_last) st = (k == TIDX_LAST) ? ST_NO_PATH_LEN : ST_TRANSPORT_CUT;
          else if (k == TIDX_LAST) nxt = ROLE_PATH_LEN;
        end
        ROLE_PATH_LEN: begin
          path_len_byte = b;
          pb = (int'(b[7:6]) + 1) * int'(b[5:0]);
          if (pb > int'(max_path)) begin
            if (is_last) st = ST_PATH_TOO_LONG;
            else nxt = ROLE_DISCARD;
          end else begin
            path_left = 8'(pb);
            if (is_last) st = (pb > 0) ? ST_PATH_CUT : ST_OK;
            else nxt = (pb > 0) ? ROLE_PATH : ROLE_PAYLOAD;
          end
        end
        ROLE_PATH: begin
          if (path_left > 0) path_left--;
          if (is_last) st = (path_left > 0) ? ST_PATH_CUT : ST_OK;
          else if (path_left == 0) nxt = ROLE_PAYLOAD;
        end
        ROLE_PAYLOAD: begin
          if (payload_count < payload_cap) payload_count++;
        end
        default: begin
          if (is_last) st = ST_PATH_TOO_LONG;
        end
      endcase
      r.data_out       = b;
      r.route_type     = header_byte[1:0];
      r.payload_type   = header_byte[5:2];
      r.version        = header_byte[7:6];
      r.code_one       = code_a;
      r.code_two       = code_b;
      r.hash_bytes     = {1'b0, path_len_byte[7:6]} + 3'd1;
      r.hops           = path_len_byte[5:0];
      r.payload_length = (is_last && st == ST_OK) ? payload_count : 8'd0;
      r.status         = st;
      r.done_res       = is_last;
      if (is_last) clear_packet();
      else phase = nxt;
      want_q.push_back(r);
    endfunction

    function void flag_fault(string msg);
      faults++;
      if (faults <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (want_q.size() == 0) begin
        flag_fault($sformatf("unexpected result %p", got));
        return;
      end
      want = want_q.pop_front();
      if (got !== want) flag_fault($sformatf("expected %p, got %p", want, got));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mph_in_if  pkt();
  mph_out_if res();

  mesh_packet_header_parser i_dut (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  header_scoreboard sb = new(MAX_PACKET_DEF);
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned beats_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    parse_result_t got;
    if (!rst && pkt.valid && pkt.ready) sb.note_beat(pkt.data_byte, pkt.last);
    if (!rst && res.valid && res.ready) begin
      got.role           = role_t'(res.role);
      got.data_out       = res.data_out;
      got.route_type     = res.route_type;
      got.payload_type   = res.payload_type;
      got.version        = res.version;
      got.code_one       = res.code_one;
      got.code_two       = res.code_two;
      got.hash_bytes     = res.hash_bytes;
      got.hops           = res.hops;
      got.payload_length = res.payload_length;
      got.status         = status_t'(res.status);
      got.done_res       = res.done_res;
      sb.check_result(got);
    end
  end

  task automatic write_max_path(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(REG_MAX_PATH) << 2;
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_max_path(v);
  endtask

  task automatic send_byte(logic [7:0] b, logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      pkt.valid <= 1'b0;
      @(negedge clk);
    end
    pkt.valid     <= 1'b1;
    pkt.data_byte <= b;
    pkt.last      <= is_last;
    @(posedge clk);
    while (!pkt.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_packet(logic [7:0] frame[$]);
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic drain();
    pkt.valid <= 1'b0;
    while (sb.want_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_packet();
    logic [7:0]  frame[$];
    logic [7:0]  hdr;
    int unsigned kind;
    int unsigned hs;
    int unsigned hc;
    int unsigned hc_top;
    int unsigned cut;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(8, 1)) frame.push_back(8'($urandom));
    end else begin
      hdr = 8'($urandom);
      frame.push_back(hdr);
      if (hdr[1:0] == RT_TRANSPORT_A || hdr[1:0] == RT_TRANSPORT_B)
        repeat (4) frame.push_back(8'($urandom));
      if (kind < 18 && sb.max_path < 8'd252) begin
        // path over the limit, trailing bytes get discarded
        hs = 3;
        hc = $urandom_range(63, sb.max_path / 4 + 1);
        frame.push_back(8'((hs << 6) | hc));
        repeat ($urandom_range(4)) frame.push_back(8'($urandom));
      end else begin
        hs = $urandom_range(3);
        hc_top = sb.max_path / (hs + 1);
        if (hc_top > 63) hc_top = 63;
        if ($urandom_range(3) != 0 && hc_top > 4) hc_top = 4;
        hc = $urandom_range(hc_top, 0);
        frame.push_back(8'((hs << 6) | hc));
        repeat (hc * (hs + 1)) frame.push_back(8'($urandom));
        repeat ($urandom_range(12)) frame.push_back(8'($urandom));
      end
      if (kind < 30) begin
        cut = $urandom_range(frame.size(), 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end
    end
    send_packet(frame);
  endtask

  initial begin
    logic [7:0] path_limits[6];
    logic [7:0] frame[$];
    rst       = 1'b1;
    pkt.valid = 1'b0;
    pkt.data_byte = '0;
    pkt.last  = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    path_limits = '{8'd64, 8'd0, 8'd255, 8'd0, 8'd1, 8'd64};
    path_limits[3] = 8'($urandom_range(255));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_packet('{8'hFF});                                   // header only
    send_packet('{8'h00, 8'hFF, 8'h00});                     // transport cut
    send_packet('{8'hFF, 8'h34, 8'h12, 8'h78, 8'h56});       // no path length
    send_packet('{8'hFE, 8'hFF});                            // path too long on last
    send_packet('{8'h01, 8'h41});                            // path cut
    send_packet('{8'h02, 8'h00, 8'hAA});                     // empty path, payload
    send_packet('{8'h01, 8'hC1, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00});
    send_packet('{8'h3D, 8'h7F, 8'h11, 8'h22});              // discard after long path
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (p > 0) write_max_path(path_limits[p]);
      if (p == 0) begin
        // payload long enough to saturate the count
        frame = '{8'h01, 8'h00};
        repeat (300) frame.push_back(8'($urandom));
        send_packet(frame);
      end
      while (beats_sent < 27 + 302 + (p + 1) * 65) begin
        random_packet();
        if ($urandom_range(39) == 0) drain();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.faults == 0 && sb.want_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
